[sv/homog_pkg.sv]
package homog_pkg;

    localparam int FRAC_BITS = 32;
    localparam int NROWS     = 8;
    localparam int NCOLS     = 9;
    localparam int THR_W     = 33;
    localparam logic signed [63:0] SMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] SMIN = 64'sh8000_0000_0000_0000;
    localparam logic signed [63:0] FX_ONE = 64'sd1 <<< FRAC_BITS;

    typedef enum logic [4:0] {
        ST_IDLE, ST_LD, ST_LD_MW,
        ST_PS_RD, ST_PS_CMP, ST_PS_CHK,
        ST_SW_RA, ST_SW_RB, ST_SW_W1, ST_SW_W2,
        ST_PV_RD, ST_PV_LD, ST_NM_RD, ST_NM_DIV, ST_NM_WAIT,
        ST_EL_RD, ST_EL_F, ST_EL_RB, ST_EL_RA, ST_EL_MUL, ST_EL_MW, ST_EL_NEXT,
        ST_OUT_RD, ST_OUT, ST_SING
    } t_state;

    typedef enum logic [3:0] {
        WS_X, WS_Y, WS_U, WS_V, WS_ONE, WS_ZERO,
        WS_MULNEG, WS_DIV, WS_SUB, WS_RDATA, WS_A
    } t_wsel;

    typedef enum logic [2:0] {
        MS_UX, MS_UY, MS_VX, MS_VY, MS_FB
    } t_msel;

    typedef struct packed {
        logic       load_pt;
        logic [6:0] rd_addr;
        logic       we;
        logic [6:0] wr_addr;
        t_wsel      wsel;
        logic       ld_a;
        logic       ld_b;
        logic       ld_f;
        logic       ld_pval;
        logic       pmag_ld;
        logic       mul_start;
        t_msel      msel;
        logic       div_start;
        logic       emit;
        logic       emit_sing;
        logic       emit_last;
        logic [2:0] emit_idx;
    } t_dp_cmd;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic rd_gt_pmag;
        logic rd_lt_thr;
        logic pmag_lt_thr;
    } t_dp_stat;

    function automatic logic [63:0] mag_of(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic signed [63:0] from_mag(input logic neg, input logic [63:0] mag);
        if (neg) begin
            return mag[63] ? SMIN : -$signed(mag);
        end
        return mag[63] ? SMAX : $signed(mag);
    endfunction

    function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] d;
        d = 65'(a) - 65'(b);
        if (d[64] != d[63]) begin
            return d[64] ? SMIN : SMAX;
        end
        return d[63:0];
    endfunction

    function automatic logic signed [63:0] sat_neg(input logic signed [63:0] a);
        return (a == SMIN) ? SMAX : -a;
    endfunction

    function automatic logic signed [63:0] widen(input logic [31:0] raw);
        logic signed [63:0] s;
        s = $signed({{32{raw[31]}}, raw});
        return s <<< (FRAC_BITS - 16);
    endfunction

    function automatic logic [6:0] maddr(input logic [2:0] row, input logic [3:0] col);
        return 7'({row, 3'b000}) + 7'(row) + 7'(col);
    endfunction

endpackage

[sv/homog_mul.sv]
module homog_mul import homog_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [63:0] i_a,
    input  logic signed [63:0] i_b,
    output logic               o_done,
    output logic signed [63:0] o_res
);

    logic [63:0]  r_ma, r_mb;
    logic         r_neg;
    logic [127:0] r_acc;
    logic [1:0]   r_step;
    logic         r_act, r_fin, r_done;
    logic signed [63:0] r_res;
    logic [31:0]  w_pa, w_pb;
    logic [63:0]  w_pp;
    logic [127:0] w_sh;
    logic [63:0]  w_mag;

    always_comb begin
        w_pa = r_step[1] ? r_ma[63:32] : r_ma[31:0];
        w_pb = r_step[0] ? r_mb[63:32] : r_mb[31:0];
        w_pp = w_pa * w_pb;
        case (r_step)
            2'd0:    w_sh = 128'(w_pp);
            2'd3:    w_sh = 128'(w_pp) << 64;
            default: w_sh = 128'(w_pp) << 32;
        endcase
        if (r_acc[127:64+FRAC_BITS] != '0) begin
            w_mag = '1;
        end else begin
            w_mag = r_acc[63+FRAC_BITS:FRAC_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act  <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_ma   <= mag_of(i_a);
                r_mb   <= mag_of(i_b);
                r_neg  <= i_a[63] ^ i_b[63];
                r_acc  <= '0;
                r_step <= '0;
                r_act  <= 1'b1;
            end else if (r_act) begin
                r_acc  <= r_acc + w_sh;
                r_step <= r_step + 2'd1;
                if (r_step == 2'd3) begin
                    r_act <= 1'b0;
                    r_fin <= 1'b1;
                end
            end else if (r_fin) begin
                r_res  <= from_mag(r_neg, w_mag);
                r_fin  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

[sv/homog_div.sv]
module homog_div import homog_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [63:0] i_a,
    input  logic signed [63:0] i_b,
    output logic               o_done,
    output logic signed [63:0] o_res
);

    logic [63:0] r_rem, r_lo, r_d, r_q;
    logic        r_neg, r_run, r_fin, r_done;
    logic [5:0]  r_cnt;
    logic signed [63:0] r_res;
    logic [63:0] w_ma, w_d, w_hi, w_rs;
    logic        w_take;

    always_comb begin
        w_ma   = mag_of(i_a);
        w_d    = mag_of(i_b);
        w_hi   = w_ma >> (64 - FRAC_BITS);
        w_rs   = {r_rem[62:0], r_lo[63]};
        w_take = r_rem[63] || (w_rs >= r_d);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_neg <= i_a[63] ^ i_b[63];
                r_d   <= w_d;
                if (w_d == '0) begin
                    r_res  <= (w_ma == '0) ? 64'sd0 : (i_a[63] ? SMIN : SMAX);
                    r_done <= 1'b1;
                end else if (w_hi >= w_d) begin
                    r_res  <= from_mag(i_a[63] ^ i_b[63], '1);
                    r_done <= 1'b1;
                end else begin
                    r_rem <= w_hi;
                    r_lo  <= w_ma << FRAC_BITS;
                    r_q   <= '0;
                    r_cnt <= '0;
                    r_run <= 1'b1;
                end
            end else if (r_run) begin
                r_rem <= w_take ? (w_rs - r_d) : w_rs;
                r_q   <= {r_q[62:0], w_take};
                r_lo  <= {r_lo[62:0], 1'b0};
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_run <= 1'b0;
                    r_fin <= 1'b1;
                end
            end else if (r_fin) begin
                r_res  <= from_mag(r_neg, r_q);
                r_fin  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

[sv/homog_dp.sv]
module homog_dp import homog_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_stat           o_stat,
    input  logic [THR_W-1:0]   i_thr,
    input  logic signed [31:0] i_src_x,
    input  logic signed [31:0] i_src_y,
    input  logic signed [31:0] i_dst_x,
    input  logic signed [31:0] i_dst_y,
    output logic               o_valid,
    output logic [2:0]         o_coef_index,
    output logic signed [63:0] o_coef_value,
    output logic               o_singular,
    output logic               o_last
);

    logic signed [63:0] r_mem [NROWS*NCOLS];
    logic signed [63:0] r_rdata;
    logic signed [63:0] r_x, r_y, r_u, r_v, r_a, r_b, r_f, r_pval;
    logic [63:0]        r_pmag;
    logic               r_valid, r_sing, r_last;
    logic [2:0]         r_idx;
    logic signed [63:0] r_val;
    logic signed [63:0] w_ma, w_mb, w_mres, w_dres, w_wdata;
    logic               w_mdone, w_ddone;
    logic [63:0]        w_rmag, w_thr;

    always_comb begin
        case (i_cmd.msel)
            MS_UX:   begin w_ma = r_u; w_mb = r_x; end
            MS_UY:   begin w_ma = r_u; w_mb = r_y; end
            MS_VX:   begin w_ma = r_v; w_mb = r_x; end
            MS_VY:   begin w_ma = r_v; w_mb = r_y; end
            default: begin w_ma = r_f; w_mb = r_b; end
        endcase
        case (i_cmd.wsel)
            WS_X:      w_wdata = r_x;
            WS_Y:      w_wdata = r_y;
            WS_U:      w_wdata = r_u;
            WS_V:      w_wdata = r_v;
            WS_ONE:    w_wdata = FX_ONE;
            WS_MULNEG: w_wdata = sat_neg(w_mres);
            WS_DIV:    w_wdata = w_dres;
            WS_SUB:    w_wdata = sat_sub(r_a, w_mres);
            WS_RDATA:  w_wdata = r_rdata;
            WS_A:      w_wdata = r_a;
            default:   w_wdata = '0;
        endcase
        w_rmag = mag_of(r_rdata);
        w_thr  = 64'(i_thr);
        o_stat.mul_done    = w_mdone;
        o_stat.div_done    = w_ddone;
        o_stat.rd_gt_pmag  = w_rmag > r_pmag;
        o_stat.rd_lt_thr   = w_rmag < w_thr;
        o_stat.pmag_lt_thr = r_pmag < w_thr;
    end

    homog_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_a     (w_ma),
        .i_b     (w_mb),
        .o_done  (w_mdone),
        .o_res   (w_mres)
    );

    homog_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_a     (r_rdata),
        .i_b     (r_pval),
        .o_done  (w_ddone),
        .o_res   (w_dres)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.we) begin
            r_mem[i_cmd.wr_addr] <= w_wdata;
        end
        r_rdata <= r_mem[i_cmd.rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_pt) begin
            r_x <= widen(i_src_x);
            r_y <= widen(i_src_y);
            r_u <= widen(i_dst_x);
            r_v <= widen(i_dst_y);
        end
        if (i_cmd.ld_a)    r_a    <= r_rdata;
        if (i_cmd.ld_b)    r_b    <= r_rdata;
        if (i_cmd.ld_f)    r_f    <= r_rdata;
        if (i_cmd.ld_pval) r_pval <= r_rdata;
        if (i_cmd.pmag_ld) r_pmag <= w_rmag;
        if (i_cmd.emit) begin
            r_idx  <= i_cmd.emit_idx;
            r_val  <= i_cmd.emit_sing ? 64'sd0 : r_rdata;
            r_sing <= i_cmd.emit_sing;
            r_last <= i_cmd.emit_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit;
        end
    end

    assign o_valid      = r_valid;
    assign o_coef_index = r_idx;
    assign o_coef_value = r_val;
    assign o_singular   = r_sing;
    assign o_last       = r_last;

endmodule

[sv/homog_ctrl.sv]
module homog_ctrl import homog_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    output logic     o_busy,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state     r_state, n_state;
    logic [1:0] r_cnt, n_cnt;
    logic       r_lr, n_lr;
    logic [3:0] r_c, n_c;
    logic [2:0] r_row, n_row;
    logic [2:0] r_col, n_col;
    logic [2:0] r_piv, n_piv;
    logic       w_adv;
    logic [2:0] w_lrow;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_lr    <= 1'b0;
            r_c     <= '0;
            r_row   <= '0;
            r_col   <= '0;
            r_piv   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_lr    <= n_lr;
            r_c     <= n_c;
            r_row   <= n_row;
            r_col   <= n_col;
            r_piv   <= n_piv;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_lr    = r_lr;
        n_c     = r_c;
        n_row   = r_row;
        n_col   = r_col;
        n_piv   = r_piv;
        o_cmd   = '0;
        w_adv   = 1'b0;
        w_lrow  = {r_cnt, r_lr};
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load_pt = 1'b1;
                    n_lr    = 1'b0;
                    n_c     = '0;
                    n_state = ST_LD;
                end
            end
            ST_LD: begin
                o_cmd.wr_addr = maddr(w_lrow, r_c);
                if (r_c == 4'd6 || r_c == 4'd7) begin
                    o_cmd.mul_start = 1'b1;
                    case ({r_lr, r_c[0]})
                        2'b00:   o_cmd.msel = MS_UX;
                        2'b01:   o_cmd.msel = MS_UY;
                        2'b10:   o_cmd.msel = MS_VX;
                        default: o_cmd.msel = MS_VY;
                    endcase
                    n_state = ST_LD_MW;
                end else begin
                    o_cmd.we = 1'b1;
                    w_adv    = 1'b1;
                    case (r_c)
                        4'd0:    o_cmd.wsel = r_lr ? WS_ZERO : WS_X;
                        4'd1:    o_cmd.wsel = r_lr ? WS_ZERO : WS_Y;
                        4'd2:    o_cmd.wsel = r_lr ? WS_ZERO : WS_ONE;
                        4'd3:    o_cmd.wsel = r_lr ? WS_X : WS_ZERO;
                        4'd4:    o_cmd.wsel = r_lr ? WS_Y : WS_ZERO;
                        4'd5:    o_cmd.wsel = r_lr ? WS_ONE : WS_ZERO;
                        default: o_cmd.wsel = r_lr ? WS_V : WS_U;
                    endcase
                end
            end
            ST_LD_MW: begin
                o_cmd.wr_addr = maddr(w_lrow, r_c);
                o_cmd.wsel    = WS_MULNEG;
                if (i_stat.mul_done) begin
                    o_cmd.we = 1'b1;
                    w_adv    = 1'b1;
                    n_state  = ST_LD;
                end
            end
            ST_PS_RD: begin
                o_cmd.rd_addr = maddr(r_row, 4'(r_col));
                n_state = ST_PS_CMP;
            end
            ST_PS_CMP: begin
                if (r_row == r_col || i_stat.rd_gt_pmag) begin
                    o_cmd.pmag_ld = 1'b1;
                    n_piv = r_row;
                end
                if (r_row == 3'(NROWS - 1)) begin
                    n_state = ST_PS_CHK;
                end else begin
                    n_row   = r_row + 3'd1;
                    n_state = ST_PS_RD;
                end
            end
            ST_PS_CHK: begin
                if (i_stat.pmag_lt_thr) begin
                    n_state = ST_SING;
                end else if (r_piv != r_col) begin
                    n_c     = '0;
                    n_state = ST_SW_RA;
                end else begin
                    n_state = ST_PV_RD;
                end
            end
            ST_SW_RA: begin
                o_cmd.rd_addr = maddr(r_piv, r_c);
                n_state = ST_SW_RB;
            end
            ST_SW_RB: begin
                o_cmd.rd_addr = maddr(r_col, r_c);
                o_cmd.ld_a    = 1'b1;
                n_state = ST_SW_W1;
            end
            ST_SW_W1: begin
                o_cmd.we      = 1'b1;
                o_cmd.wr_addr = maddr(r_piv, r_c);
                o_cmd.wsel    = WS_RDATA;
                n_state = ST_SW_W2;
            end
            ST_SW_W2: begin
                o_cmd.we      = 1'b1;
                o_cmd.wr_addr = maddr(r_col, r_c);
                o_cmd.wsel    = WS_A;
                if (r_c == 4'(NCOLS - 1)) begin
                    n_state = ST_PV_RD;
                end else begin
                    n_c     = r_c + 4'd1;
                    n_state = ST_SW_RA;
                end
            end
            ST_PV_RD: begin
                o_cmd.rd_addr = maddr(r_col, 4'(r_col));
                n_state = ST_PV_LD;
            end
            ST_PV_LD: begin
                o_cmd.ld_pval = 1'b1;
                n_c     = 4'(r_col);
                n_state = ST_NM_RD;
            end
            ST_NM_RD: begin
                o_cmd.rd_addr = maddr(r_col, r_c);
                n_state = ST_NM_DIV;
            end
            ST_NM_DIV: begin
                o_cmd.div_start = 1'b1;
                n_state = ST_NM_WAIT;
            end
            ST_NM_WAIT: begin
                o_cmd.wr_addr = maddr(r_col, r_c);
                o_cmd.wsel    = WS_DIV;
                if (i_stat.div_done) begin
                    o_cmd.we = 1'b1;
                    if (r_c == 4'(NCOLS - 1)) begin
                        n_row   = '0;
                        n_state = ST_EL_RD;
                    end else begin
                        n_c     = r_c + 4'd1;
                        n_state = ST_NM_RD;
                    end
                end
            end
            ST_EL_RD: begin
                o_cmd.rd_addr = maddr(r_row, 4'(r_col));
                n_state = (r_row == r_col) ? ST_EL_NEXT : ST_EL_F;
            end
            ST_EL_F: begin
                o_cmd.ld_f = 1'b1;
                if (i_stat.rd_lt_thr) begin
                    n_state = ST_EL_NEXT;
                end else begin
                    n_c     = 4'(r_col);
                    n_state = ST_EL_RB;
                end
            end
            ST_EL_RB: begin
                o_cmd.rd_addr = maddr(r_col, r_c);
                n_state = ST_EL_RA;
            end
            ST_EL_RA: begin
                o_cmd.ld_b    = 1'b1;
                o_cmd.rd_addr = maddr(r_row, r_c);
                n_state = ST_EL_MUL;
            end
            ST_EL_MUL: begin
                o_cmd.ld_a      = 1'b1;
                o_cmd.mul_start = 1'b1;
                o_cmd.msel      = MS_FB;
                n_state = ST_EL_MW;
            end
            ST_EL_MW: begin
                o_cmd.wr_addr = maddr(r_row, r_c);
                o_cmd.wsel    = WS_SUB;
                if (i_stat.mul_done) begin
                    o_cmd.we = 1'b1;
                    if (r_c == 4'(NCOLS - 1)) begin
                        n_state = ST_EL_NEXT;
                    end else begin
                        n_c     = r_c + 4'd1;
                        n_state = ST_EL_RB;
                    end
                end
            end
            ST_EL_NEXT: begin
                if (r_row == 3'(NROWS - 1)) begin
                    if (r_col == 3'(NROWS - 1)) begin
                        n_row   = '0;
                        n_state = ST_OUT_RD;
                    end else begin
                        n_col   = r_col + 3'd1;
                        n_row   = r_col + 3'd1;
                        n_state = ST_PS_RD;
                    end
                end else begin
                    n_row   = r_row + 3'd1;
                    n_state = ST_EL_RD;
                end
            end
            ST_OUT_RD: begin
                o_cmd.rd_addr = maddr(r_row, 4'(NCOLS - 1));
                n_state = ST_OUT;
            end
            ST_OUT: begin
                o_cmd.emit      = 1'b1;
                o_cmd.emit_idx  = r_row;
                o_cmd.emit_last = (r_row == 3'(NROWS - 1));
                if (r_row == 3'(NROWS - 1)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_row   = r_row + 3'd1;
                    n_state = ST_OUT_RD;
                end
            end
            ST_SING: begin
                o_cmd.emit      = 1'b1;
                o_cmd.emit_sing = 1'b1;
                o_cmd.emit_last = 1'b1;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (w_adv) begin
            if (r_c == 4'(NCOLS - 1)) begin
                n_c = '0;
                if (r_lr) begin
                    n_cnt = r_cnt + 2'd1;
                    if (r_cnt == 2'd3) begin
                        n_col   = '0;
                        n_row   = '0;
                        n_state = ST_PS_RD;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end else begin
                    n_lr = 1'b1;
                end
            end else begin
                n_c = r_c + 4'd1;
            end
        end
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

[sv/four_point_homography_solver.sv]
// channel   direction  handshake                  payload
// point     in         i_start high, o_busy low   i_src_x, i_src_y, i_dst_x, i_dst_y
// coef      out        o_valid, one cycle         o_coef_index, o_coef_value, o_singular, o_last
// config    in/out     psel, penable, pwrite      paddr, pwdata, prdata, pready
//
// points 1 to 3 each take 18 matrix writes and four multiplies
// the 4th point adds the solve, paced by the divider
// (one quotient bit a cycle), the four-pass 32x32 multiplier and the single matrix memory
// o_busy is high from an accepted point until it is stored, or the 4th's last result is issued
// synchronous active-low reset clears control and sets the threshold to 4
// results cannot be stalled by the receiver
module four_point_homography_solver import homog_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic signed [31:0] i_src_x,
    input  logic signed [31:0] i_src_y,
    input  logic signed [31:0] i_dst_x,
    input  logic signed [31:0] i_dst_y,
    output logic               o_valid,
    output logic [2:0]         o_coef_index,
    output logic signed [63:0] o_coef_value,
    output logic               o_singular,
    output logic               o_last,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready
);

    logic [THR_W-1:0] r_thr;
    t_dp_cmd          w_cmd;
    t_dp_stat         w_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_W'(4);
        end else if (psel && penable && pwrite && !paddr[3]) begin
            r_thr <= pwdata[THR_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = paddr[3] ? 64'd0 : 64'(r_thr);

    homog_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .o_busy  (o_busy),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    homog_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_thr        (r_thr),
        .i_src_x      (i_src_x),
        .i_src_y      (i_src_y),
        .i_dst_x      (i_dst_x),
        .i_dst_y      (i_dst_y),
        .o_valid      (o_valid),
        .o_coef_index (o_coef_index),
        .o_coef_value (o_coef_value),
        .o_singular   (o_singular),
        .o_last       (o_last)
    );

    a_sing_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_singular |-> o_coef_value == 64'sd0 && o_last && o_coef_index == 3'd0)
        else $error("singular result malformed");

    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last && !o_singular |-> o_coef_index == 3'(NROWS - 1))
        else $error("last coefficient index wrong");

    a_busy_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_busy) |-> $past(i_start))
        else $error("busy without request");

    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(o_busy))
        else $error("result while idle");

endmodule
